// ----- design/frf_pkg.sv -----
package frf_pkg;

  // field widths fixed by the stream format
  localparam int CFG_W   = 11;
  localparam int COORD_W = 11;
  localparam int COL_W   = 10;
  localparam int ROW_W   = 10;
  localparam int RUN_W   = 11;

  // hard cap on the row length the column store serves
  localparam int ROW_CAP = 1024;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH   = 2'd0,
    CFG_WINDOW_HEIGHT = 2'd1,
    CFG_WINDOW_WIDTH  = 2'd2
  } cfg_idx_t;

  // per-pixel control carried from the accept stage to the update stage
  typedef struct packed {
    logic blocked;
    logic last;
    logic first_row;
    logic row_end;
    logic fwd;
  } pix_ctrl_t;

endpackage

// ----- design/frf_ram.sv -----
module frf_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on a same-edge write, holds when idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/free_rectangle_finder_top.sv -----
// pipeline: a pixel beat is registered into the update stage, its result beat then into the result register
// throughput: one pixel per cycle while the result beat is taken; the column store read/write pair
//   sets the pace, a same-column hit on the previous pixel is forwarded around the store
// reset: counters, run, match flag, handshake state and registers return to defaults;
//   the column height store is not cleared, the first row of a frame never uses its value
module free_rectangle_finder_top #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,   // [0] pixel_blocked, rest zero
  input  logic                       s_axis_tlast,   // frame_end
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [47:0]                m_axis_tdata,   // top_row, left_col, bottom_row,
                                                     // right_col (11 bits each), pad
  output logic                       m_axis_tuser,   // found
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [frf_pkg::CFG_W-1:0]  cfg_data
);

  import frf_pkg::*;

  localparam int COL_DEPTH = (MAX_COLS < ROW_CAP) ? MAX_COLS : ROW_CAP;
  localparam int ADDR_W    = (COL_DEPTH > 1) ? $clog2(COL_DEPTH) : 1;
  localparam int HGT_W     = $clog2(MAX_ROWS + 1);
  localparam int CMP_W     = (HGT_W > CFG_W) ? HGT_W : CFG_W;

  // configuration
  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] window_height;
  logic [CFG_W-1:0] window_width;

  // frame position
  logic [COL_W-1:0] col_index;
  logic [ROW_W-1:0] row_index;

  // update stage
  logic             s1_valid;
  pix_ctrl_t        s1_ctrl;
  logic [COL_W-1:0] s1_col;
  logic [ROW_W-1:0] s1_row;
  logic [HGT_W-1:0] s1_fwd_h;
  logic [RUN_W-1:0] run_length;
  logic             match_seen;

  // result register
  logic               out_valid;
  logic               out_found;
  logic [COORD_W-1:0] out_top;
  logic [COORD_W-1:0] out_left;
  logic [COORD_W-1:0] out_bottom;
  logic [COORD_W-1:0] out_right;

  logic [CFG_W-1:0] lim;
  logic [COL_W-1:0] col_cur;
  logic             row_wrap;
  logic             in_fire;
  logic             s1_adv;
  logic [HGT_W-1:0] ram_q;
  logic [HGT_W-1:0] above;
  logic [HGT_W-1:0] h;
  logic             qualify;
  logic [RUN_W-1:0] run_new;
  logic             hit;
  logic             emit;

  // handshake
  assign s1_adv        = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_adv;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= CFG_W'(1024);
      window_height <= CFG_W'(1);
      window_width  <= CFG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH:   image_width   <= cfg_data;
        CFG_WINDOW_HEIGHT: window_height <= cfg_data;
        CFG_WINDOW_WIDTH:  window_width  <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective row length and clamped column
  always_comb begin
    lim = image_width;
    if (lim > CFG_W'(COL_DEPTH)) lim = CFG_W'(COL_DEPTH);
    if (lim == '0) lim = CFG_W'(1);
    col_cur  = ({1'b0, col_index} >= lim) ? COL_W'(lim - CFG_W'(1)) : col_index;
    row_wrap = ({1'b0, col_cur} + CFG_W'(1)) >= lim;
  end

  // raster position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col_index <= '0;
      row_index <= '0;
    end else if (in_fire) begin
      if (s_axis_tlast) begin
        col_index <= '0;
        row_index <= '0;
      end else if (row_wrap) begin
        col_index <= '0;
        row_index <= row_index + ROW_W'(1);
      end else begin
        col_index <= col_cur + COL_W'(1);
      end
    end
  end

  // column height store
  frf_ram #(
    .WIDTH (HGT_W),
    .DEPTH (COL_DEPTH)
  ) u_height (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col[ADDR_W-1:0]),
    .wdata (h),
    .re    (in_fire),
    .raddr (col_cur[ADDR_W-1:0]),
    .rdata (ram_q)
  );

  // update stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // update stage payload, forward the height being written this edge
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ctrl.blocked   <= s_axis_tdata[0];
      s1_ctrl.last      <= s_axis_tlast;
      s1_ctrl.first_row <= (row_index == '0);
      s1_ctrl.row_end   <= row_wrap;
      s1_ctrl.fwd       <= s1_adv && (s1_col == col_cur);
      s1_col            <= col_cur;
      s1_row            <= row_index;
      s1_fwd_h          <= h;
    end
  end

  // new height, run and match
  always_comb begin
    if (s1_ctrl.first_row) begin
      above = '0;
    end else if (s1_ctrl.fwd) begin
      above = s1_fwd_h;
    end else begin
      above = ram_q;
    end
    if (s1_ctrl.blocked) begin
      h = '0;
    end else if (above >= HGT_W'(MAX_ROWS)) begin
      h = HGT_W'(MAX_ROWS);
    end else begin
      h = above + HGT_W'(1);
    end
    qualify = CMP_W'(h) >= CMP_W'(window_height);
    if (!qualify) begin
      run_new = '0;
    end else if (run_length == '1) begin
      run_new = run_length;
    end else begin
      run_new = run_length + RUN_W'(1);
    end
    hit  = !match_seen && (run_new == window_width);
    emit = hit || (s1_ctrl.last && !match_seen);
  end

  // run and match state
  always_ff @(posedge clk) begin
    if (rst) begin
      run_length <= '0;
      match_seen <= 1'b0;
    end else if (s1_adv) begin
      run_length <= (s1_ctrl.last || s1_ctrl.row_end) ? '0 : run_new;
      match_seen <= s1_ctrl.last ? 1'b0 : (match_seen || hit);
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload, 1-based coordinates modulo 2048
  always_ff @(posedge clk) begin
    if (s1_adv && emit) begin
      out_found <= hit;
      if (hit) begin
        out_top    <= COORD_W'({1'b0, s1_row}) + COORD_W'(2) - window_height;
        out_left   <= COORD_W'({1'b0, s1_col}) + COORD_W'(2) - window_width;
        out_bottom <= COORD_W'({1'b0, s1_row}) + COORD_W'(1);
        out_right  <= COORD_W'({1'b0, s1_col}) + COORD_W'(1);
      end else begin
        out_top    <= '0;
        out_left   <= '0;
        out_bottom <= '0;
        out_right  <= '0;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_found;
  assign m_axis_tdata  = {4'b0, out_right, out_bottom, out_left, out_top};

  // a not-found beat only comes from the last pixel of a frame
  a_notfound_at_end: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && emit && !hit) |-> s1_ctrl.last)
    else $error("not-found result away from frame end");

  // at most one found result per frame
  a_single_match: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && hit) |-> !match_seen)
    else $error("second match in one frame");

  // a pixel accepted behind a same-column pixel leaving the update stage carries the forward flag
  a_fwd_valid: assert property (@(posedge clk) disable iff (rst)
    (in_fire && s1_adv && (s1_col == col_cur)) |=> (s1_valid && s1_ctrl.fwd))
    else $error("height forward lost");

endmodule

// ----- bench/free_rectangle_finder_top_tb.sv -----
`timescale 1ns / 1ps

module free_rectangle_finder_top_tb;
  import frf_pkg::*;

  // one result beat as seen on the output stream
  typedef struct {
    bit         found;
    bit [10:0]  top_row;
    bit [10:0]  left_col;
    bit [10:0]  bottom_row;
    bit [10:0]  right_col;
  } rect_t;

  logic                       clk;
  logic                       rst;
  logic                       s_axis_tvalid;
  logic                       s_axis_tready;
  logic [7:0]                 s_axis_tdata;
  logic                       s_axis_tlast;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready;
  logic [47:0]                m_axis_tdata;
  logic                       m_axis_tuser;
  logic                       cfg_we;
  logic [1:0]                 cfg_index;
  logic [CFG_W-1:0]           cfg_data;

  free_rectangle_finder_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // predictor state: column free counts, row run, position, match flag
  bit [10:0]  free_height [ROW_CAP];
  bit [10:0]  run_cols;
  bit [9:0]   row_pos;
  bit [9:0]   col_pos;
  bit         frame_matched;
  bit [10:0]  img_width_q;
  bit [10:0]  win_height_q;
  bit [10:0]  win_width_q;

  rect_t      pending_rects [$];
  int         mismatch_cnt;
  int         pixels_sent;
  int         hold_len;
  bit         src_gaps_on;
  bit         snk_gaps_on;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // advance the frame search by one pixel and queue any result it causes
  function void track_pixel(input bit blocked, input bit last);
    int unsigned lim;
    int unsigned col;
    int unsigned above;
    int unsigned h;
    bit          hit;
    rect_t       r;
    lim = img_width_q;
    if (lim > ROW_CAP) lim = ROW_CAP;
    if (lim == 0) lim = 1;
    col = col_pos;
    if (col >= lim) col = lim - 1;
    if (blocked) begin
      h = 0;
    end else begin
      above = (row_pos == 0) ? 0 : free_height[col[9:0]];
      h = (above >= 1024) ? 1024 : above + 1;
    end
    free_height[col[9:0]] = h[10:0];
    if (h < win_height_q) run_cols = '0;
    else if (run_cols != 11'h7FF) run_cols = run_cols + 1'b1;
    hit = 1'b0;
    if (!frame_matched && run_cols == win_width_q) begin
      frame_matched = 1'b1;
      hit = 1'b1;
      r.found      = 1'b1;
      r.top_row    = 11'(row_pos + 2 - win_height_q);
      r.left_col   = 11'(col + 2 - win_width_q);
      r.bottom_row = 11'(row_pos + 1);
      r.right_col  = 11'(col + 1);
      pending_rects.push_back(r);
    end
    if (last) begin
      // frame closes with no match: not-found beat
      if (!hit && !frame_matched) begin
        r = '{default: 0};
        pending_rects.push_back(r);
      end
      run_cols = '0;
      row_pos = '0;
      col_pos = '0;
      frame_matched = 1'b0;
    end else if (col + 1 >= lim) begin
      col_pos = '0;
      row_pos = row_pos + 1'b1;
      run_cols = '0;
    end else begin
      col_pos = 10'(col + 1);
    end
  endfunction

  // send one pixel beat, entered and left at a falling edge
  task automatic send_pixel(input bit blocked, input bit last);
    int gap;
    gap = src_gaps_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, blocked};
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    track_pixel(blocked, last);
    pixels_sent++;
    @(negedge clk);
  endtask

  // drop the source and let the block drain all pending results
  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_rects.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // write all three registers once the block is quiet
  task automatic program_regs(input bit [10:0] img_w, input bit [10:0] win_h,
                              input bit [10:0] win_w);
    wait_quiet();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IMAGE_WIDTH;
    cfg_data  <= img_w;
    @(negedge clk);
    cfg_index <= CFG_WINDOW_HEIGHT;
    cfg_data  <= win_h;
    @(negedge clk);
    cfg_index <= CFG_WINDOW_WIDTH;
    cfg_data  <= win_w;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    img_width_q  = img_w;
    win_height_q = win_h;
    win_width_q  = win_w;
  endtask

  // result sink: per-beat random hold-off, plus a long hold on request
  initial begin : result_sink
    int gap;
    m_axis_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_len > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_len) @(negedge clk);
        hold_len = 0;
      end
      gap = snk_gaps_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid && hold_len == 0);
      @(negedge clk);
    end
  end

  // compare each result beat with the oldest expected rectangle
  always @(posedge clk) begin : check_rects
    rect_t       exp_r;
    rect_t       act_r;
    int unsigned exp_f [5];
    int unsigned act_f [5];
    string       fname [5];
    fname = '{"found", "top_row", "left_col", "bottom_row", "right_col"};
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      act_r.found      = m_axis_tuser;
      act_r.top_row    = m_axis_tdata[10:0];
      act_r.left_col   = m_axis_tdata[21:11];
      act_r.bottom_row = m_axis_tdata[32:22];
      act_r.right_col  = m_axis_tdata[43:33];
      if (pending_rects.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected beat, expected none, actual %0d/%0d/%0d/%0d/%0d",
                 $time, act_r.found, act_r.top_row, act_r.left_col,
                 act_r.bottom_row, act_r.right_col);
      end else begin
        exp_r = pending_rects.pop_front();
        exp_f = '{exp_r.found, exp_r.top_row, exp_r.left_col, exp_r.bottom_row,
                  exp_r.right_col};
        act_f = '{act_r.found, act_r.top_row, act_r.left_col, act_r.bottom_row,
                  act_r.right_col};
        for (int i = 0; i < 5; i++) begin
          if (exp_f[i] != act_f[i]) begin
            mismatch_cnt++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname[i],
                     exp_f[i], act_f[i]);
          end
        end
      end
    end
  end

  // default registers: match mid-frame, frame end after a match is silent
  task automatic test_reset_defaults();
    send_pixel(1'b1, 1'b0);
    send_pixel(1'b0, 1'b0);
    send_pixel(1'b0, 1'b1);
  endtask

  // zero image width acts as one column; match lands on the last pixel
  task automatic test_last_pixel_match();
    program_regs(11'd0, 11'd2, 11'd1);
    send_pixel(1'b0, 1'b0);
    send_pixel(1'b0, 1'b1);
  endtask

  // two-row window reached in the second row after a blocked column
  task automatic test_two_row_match();
    program_regs(11'd3, 11'd2, 11'd2);
    repeat (3) send_pixel(1'b0, 1'b0);
    send_pixel(1'b1, 1'b0);
    send_pixel(1'b0, 1'b0);
    send_pixel(1'b0, 1'b1);
  endtask

  // zero window width matches an empty run; zero height lets any pixel qualify
  task automatic test_zero_window();
    program_regs(11'd2, 11'd1, 11'd0);
    send_pixel(1'b1, 1'b1);
    program_regs(11'd4, 11'd0, 11'd3);
    repeat (3) send_pixel(1'b1, 1'b0);
    send_pixel(1'b1, 1'b1);
  endtask

  // window taller than any frame: not-found at frame end
  task automatic test_no_match();
    program_regs(11'd2, 11'd2047, 11'd1);
    send_pixel(1'b0, 1'b0);
    send_pixel(1'b0, 1'b1);
  endtask

  // oversize image width clamps to a full row; short frame stays in row zero
  task automatic test_wide_row();
    program_regs(11'd2047, 11'd1, 11'd3);
    send_pixel(1'b1, 1'b0);
    repeat (20) send_pixel(1'b0, 1'b0);
    send_pixel(1'b0, 1'b1);
  endtask

  // receiver holds off while one-pixel frames keep coming
  task automatic test_output_stall();
    program_regs(11'd1, 11'd1, 11'd1);
    hold_len = 200;
    repeat (40) send_pixel($urandom_range(0, 1), 1'b1);
  endtask

  // random frames, random windows, random gaps on both sides
  task automatic test_random_frames();
    int          base_pixels;
    int          eff_w;
    int          len;
    int          dens;
    int          pick;
    bit [10:0]   img_w;
    bit [10:0]   win_h;
    bit [10:0]   win_w;
    base_pixels = pixels_sent;
    while (pixels_sent - base_pixels < 320) begin
      if ($urandom_range(0, 9) < 7) begin
        img_w = 11'($urandom_range(0, 12));
        eff_w = (img_w == 0) ? 1 : img_w;
        pick = $urandom_range(0, 7);
        win_h = (pick == 0) ? 11'd0 : (pick == 1) ? 11'd2047 : 11'($urandom_range(1, 4));
        pick = $urandom_range(0, 7);
        win_w = (pick == 0) ? 11'd0 : (pick == 1) ? 11'd2047 : 11'($urandom_range(1, eff_w));
        program_regs(img_w, win_h, win_w);
      end
      eff_w = (img_width_q == 0) ? 1 : (img_width_q > ROW_CAP) ? ROW_CAP : img_width_q;
      src_gaps_on = $urandom_range(0, 3) != 0;
      snk_gaps_on = $urandom_range(0, 3) != 0;
      dens = $urandom_range(0, 50);
      len  = $urandom_range(1, eff_w * 5);
      for (int i = 0; i < len; i++)
        send_pixel($urandom_range(0, 99) < dens, i == len - 1);
    end
    src_gaps_on = 1'b1;
    snk_gaps_on = 1'b1;
  endtask

  // test sequence
  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_IMAGE_WIDTH;
    cfg_data      = '0;
    mismatch_cnt  = 0;
    pixels_sent   = 0;
    hold_len      = 0;
    src_gaps_on   = 1'b1;
    snk_gaps_on   = 1'b1;
    run_cols      = '0;
    row_pos       = '0;
    col_pos       = '0;
    frame_matched = 1'b0;
    img_width_q   = 11'd1024;
    win_height_q  = 11'd1;
    win_width_q   = 11'd1;
    repeat (5) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_reset_defaults();
    test_last_pixel_match();
    test_two_row_match();
    test_zero_window();
    test_no_match();
    test_wide_row();
    test_output_stall();
    test_random_frames();

    wait_quiet();
    if (mismatch_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
